// ===== rtl/legged_gait_phase_scheduler_top_macros.svh =====
`ifndef LEGGED_GAIT_PHASE_SCHEDULER_TOP_MACROS_SVH
`define LEGGED_GAIT_PHASE_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define LGPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lgps check failed");

// next-cycle implication, checked outside reset
`define LGPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lgps check failed");

`endif

// ===== rtl/lgps_pkg.sv =====
`default_nettype none

package lgps_pkg;

  localparam int unsigned LEG_COUNT      = 4;
  localparam int unsigned TIME_BITS_DEF  = 21;
  localparam int unsigned TICK_W         = 16;
  localparam int unsigned STANCE_W       = 20;
  localparam int unsigned TAG_W          = 3;
  localparam int unsigned SEL_W          = 3;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned ADDR_W         = 5;
  localparam int unsigned SWITCH_WINDOW_US = 2000;

  localparam logic [TICK_W-1:0]   TICK_RST  = 16'd1000;
  localparam logic [STANCE_W-1:0] STAND_RST = 20'd200000;
  localparam logic [STANCE_W-1:0] TROT_RST  = 20'd250000;
  localparam logic [STANCE_W-1:0] PACE_RST  = 20'd250000;
  localparam logic [STANCE_W-1:0] WALK_RST  = 20'd600000;

  typedef enum logic [1:0] {
    GAIT_STAND = 2'd0,
    GAIT_TROT  = 2'd1,
    GAIT_PACE  = 2'd2,
    GAIT_WALK  = 2'd3
  } gait_e;

  typedef enum logic [2:0] {
    REG_TICK  = 3'd0,
    REG_STAND = 3'd1,
    REG_TROT  = 3'd2,
    REG_PACE  = 3'd3,
    REG_WALK  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [TICK_W-1:0]   tick_us;
    logic [STANCE_W-1:0] stance_stand;
    logic [STANCE_W-1:0] stance_trot;
    logic [STANCE_W-1:0] stance_pace;
    logic [STANCE_W-1:0] stance_walk;
  } cfg_t;

  typedef struct packed {
    logic [TAG_W-1:0]     request_tag;
    logic [SEL_W-1:0]     gait_select;
    logic [LEG_COUNT-1:0] foot_contact;
  } item_t;

  typedef struct packed {
    logic [LEG_COUNT-1:0] leg_stance;
    logic [1:0]           phase_index;
    gait_e                active_gait;
    logic                 gait_changed;
    logic                 phase_advanced;
  } res_t;

  function automatic logic [2:0] gait_rows(gait_e g);
    logic [2:0] r;
    unique case (g)
      GAIT_STAND: r = 3'd1;
      GAIT_TROT:  r = 3'd2;
      GAIT_PACE:  r = 3'd2;
      GAIT_WALK:  r = 3'd4;
      default:    r = 3'd1;
    endcase
    return r;
  endfunction

  function automatic logic [LEG_COUNT-1:0] gait_pattern(gait_e g, logic [1:0] row);
    logic [LEG_COUNT-1:0] p;
    unique case (g)
      GAIT_STAND: p = 4'hF;
      GAIT_TROT:  p = row[0] ? 4'h6 : 4'h9;
      GAIT_PACE:  p = row[0] ? 4'hC : 4'h3;
      GAIT_WALK: begin
        unique case (row)
          2'd0:    p = 4'hE;
          2'd1:    p = 4'h7;
          2'd2:    p = 4'hB;
          2'd3:    p = 4'hD;
          default: p = 4'hE;
        endcase
      end
      default:    p = 4'hF;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] contact_count(logic [LEG_COUNT-1:0] v);
    return {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lgps_cfg.sv =====
`default_nettype none

module lgps_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lgps_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [lgps_pkg::DATA_W-1:0]   pwdata,
  output logic      [lgps_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output lgps_pkg::cfg_t                     cfg_o
);

  lgps_pkg::cfg_t     cfg_q, cfg_d;
  lgps_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = lgps_pkg::reg_idx_e'(paddr[lgps_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        lgps_pkg::REG_TICK:  cfg_d.tick_us      = pwdata[lgps_pkg::TICK_W-1:0];
        lgps_pkg::REG_STAND: cfg_d.stance_stand = pwdata[lgps_pkg::STANCE_W-1:0];
        lgps_pkg::REG_TROT:  cfg_d.stance_trot  = pwdata[lgps_pkg::STANCE_W-1:0];
        lgps_pkg::REG_PACE:  cfg_d.stance_pace  = pwdata[lgps_pkg::STANCE_W-1:0];
        lgps_pkg::REG_WALK:  cfg_d.stance_walk  = pwdata[lgps_pkg::STANCE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lgps_pkg::REG_TICK:  prdata = {16'd0, cfg_q.tick_us};
      lgps_pkg::REG_STAND: prdata = {12'd0, cfg_q.stance_stand};
      lgps_pkg::REG_TROT:  prdata = {12'd0, cfg_q.stance_trot};
      lgps_pkg::REG_PACE:  prdata = {12'd0, cfg_q.stance_pace};
      lgps_pkg::REG_WALK:  prdata = {12'd0, cfg_q.stance_walk};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_us      <= lgps_pkg::TICK_RST;
      cfg_q.stance_stand <= lgps_pkg::STAND_RST;
      cfg_q.stance_trot  <= lgps_pkg::TROT_RST;
      cfg_q.stance_pace  <= lgps_pkg::PACE_RST;
      cfg_q.stance_walk  <= lgps_pkg::WALK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lgps_core.sv =====
`default_nettype none

module lgps_core #(
  parameter int unsigned TIME_BITS = lgps_pkg::TIME_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire lgps_pkg::item_t item_i,
  input  wire lgps_pkg::cfg_t  cfg_i,
  output lgps_pkg::res_t      res_o
);

  localparam int unsigned EW = TIME_BITS + 3;

  logic [1:0]                    row_q, row_d;
  logic [TIME_BITS-1:0]          elapsed_q, elapsed_d;
  lgps_pkg::gait_e               gait_q, gait_d;
  logic [lgps_pkg::TAG_W-1:0]    tag_q, tag_d;
  logic [lgps_pkg::LEG_COUNT-1:0] contact_q;

  logic                 tag_take, changed, advance, early_ok;
  logic [1:0]           row_sw;
  logic [2:0]           rows, row_inc;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] elapsed_acc;
  logic [EW-1:0]        e5, t4, t6, t_ext;
  logic [lgps_pkg::STANCE_W-1:0] t_sel;

  // gait switch only inside the window after a phase start
  assign tag_take = (item_i.request_tag != tag_q) &&
                    (elapsed_q <= TIME_BITS'(lgps_pkg::SWITCH_WINDOW_US));
  assign changed  = tag_take && !item_i.gait_select[2];
  assign gait_d   = changed ? lgps_pkg::gait_e'(item_i.gait_select[1:0]) : gait_q;
  assign tag_d    = tag_take ? item_i.request_tag : tag_q;
  assign rows     = lgps_pkg::gait_rows(gait_d);
  assign row_sw   = (changed && ({1'b0, row_q} >= rows)) ? 2'd0 : row_q;

  // saturating time accumulate
  assign sum         = {1'b0, elapsed_q} + (TIME_BITS + 1)'(cfg_i.tick_us);
  assign elapsed_acc = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

  assign t_sel = (gait_d == lgps_pkg::GAIT_PACE) ? cfg_i.stance_pace : cfg_i.stance_walk;
  assign t_ext = EW'(t_sel);
  assign t4    = t_ext << 2;
  assign t6    = (t_ext << 2) + (t_ext << 1);
  assign e5    = (EW'(elapsed_acc) << 2) + EW'(elapsed_acc);
  assign early_ok = lgps_pkg::contact_count(item_i.foot_contact) >
                    lgps_pkg::contact_count(contact_q);

  always_comb begin
    advance   = 1'b0;
    elapsed_d = elapsed_acc;
    unique case (gait_d)
      lgps_pkg::GAIT_STAND: begin
        if (elapsed_acc >= TIME_BITS'(cfg_i.stance_stand)) elapsed_d = '0;
      end
      lgps_pkg::GAIT_TROT: begin
        advance = elapsed_acc > TIME_BITS'(cfg_i.stance_trot);
      end
      default: begin
        advance = (e5 > t6) || ((e5 > t4) && early_ok);
      end
    endcase
    if (advance) elapsed_d = '0;
  end

  assign row_inc = {1'b0, row_sw} + 3'd1;
  assign row_d   = advance ? ((row_inc >= rows) ? 2'd0 : row_inc[1:0]) : row_sw;

  always_comb begin
    res_o.leg_stance     = lgps_pkg::gait_pattern(gait_d, row_d);
    res_o.phase_index    = row_d;
    res_o.active_gait    = gait_d;
    res_o.gait_changed   = changed;
    res_o.phase_advanced = advance;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      elapsed_q <= '0;
      gait_q    <= lgps_pkg::GAIT_STAND;
      tag_q     <= '0;
      contact_q <= '0;
    end else if (step_i) begin
      row_q     <= row_d;
      elapsed_q <= elapsed_d;
      gait_q    <= gait_d;
      tag_q     <= tag_d;
      contact_q <= item_i.foot_contact;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/legged_gait_phase_scheduler_top.sv =====
// pipeline: an accepted item waits in the input register; its result is written when it steps (input reg, result reg)
// throughput: one item per cycle unless a valid result stalls; a valid result register holds while out_ready_i is low
// the per-tick state update sits between the input register and the result register
// reset: rst_ni async active low clears gait state, tag, phase time and both valid flags
// configuration registers reset to tick 1000 us and stance times 200/250/250/600 ms
`default_nettype none

module legged_gait_phase_scheduler_top #(
  parameter int unsigned TIME_BITS = lgps_pkg::TIME_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lgps_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [lgps_pkg::DATA_W-1:0]       pwdata,
  output logic      [lgps_pkg::DATA_W-1:0]       prdata,
  output logic                                   pready,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [lgps_pkg::TAG_W-1:0]        request_tag_i,
  input  wire logic [lgps_pkg::SEL_W-1:0]        gait_select_i,
  input  wire logic [lgps_pkg::LEG_COUNT-1:0]    foot_contact_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [lgps_pkg::LEG_COUNT-1:0]    leg_stance_o,
  output logic      [1:0]                        phase_index_o,
  output logic      [1:0]                        active_gait_o,
  output logic                                   gait_changed_o,
  output logic                                   phase_advanced_o
);

  lgps_pkg::cfg_t  cfg;
  lgps_pkg::item_t item_q;
  lgps_pkg::res_t  res, res_q;
  logic            in_valid_q, out_valid_q, step;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  lgps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lgps_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (step) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.request_tag  <= request_tag_i;
      item_q.gait_select  <= gait_select_i;
      item_q.foot_contact <= foot_contact_i;
    end
    if (step) res_q <= res;
  end

  assign out_valid_o      = out_valid_q;
  assign leg_stance_o     = res_q.leg_stance;
  assign phase_index_o    = res_q.phase_index;
  assign active_gait_o    = res_q.active_gait;
  assign gait_changed_o   = res_q.gait_changed;
  assign phase_advanced_o = res_q.phase_advanced;

endmodule

`default_nettype wire

// ===== rtl/lgps_checker.sv =====
`default_nettype none
`include "legged_gait_phase_scheduler_top_macros.svh"

module lgps_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [lgps_pkg::LEG_COUNT-1:0] leg_stance_o,
  input wire logic [1:0]                     phase_index_o,
  input wire logic [1:0]                     active_gait_o,
  input wire logic                           phase_advanced_o
);

  logic [lgps_pkg::LEG_COUNT+4:0] out_payload;
  logic [lgps_pkg::LEG_COUNT-1:0] table_stance;
  logic                           stand_gait;
  logic                           two_row_gait;

  assign out_payload  = {leg_stance_o, phase_index_o, active_gait_o, phase_advanced_o};
  assign table_stance = lgps_pkg::gait_pattern(lgps_pkg::gait_e'(active_gait_o),
                                               phase_index_o);
  assign stand_gait   = (active_gait_o == lgps_pkg::GAIT_STAND);
  assign two_row_gait = (active_gait_o == lgps_pkg::GAIT_TROT) ||
                        (active_gait_o == lgps_pkg::GAIT_PACE);

  // a stalled result stays put
  `LGPS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_payload))

  // stand never steps its single row
  `LGPS_ASSERT_NOW(a_stand_row, out_valid_o && stand_gait, !phase_advanced_o && !(|phase_index_o))

  // two-row gaits stay in rows zero and one
  `LGPS_ASSERT_NOW(a_two_rows, out_valid_o && two_row_gait, !phase_index_o[1])

  // leg pattern matches the gait table row
  `LGPS_ASSERT_NOW(a_pattern, out_valid_o, leg_stance_o == table_stance)

endmodule

bind legged_gait_phase_scheduler_top lgps_checker u_lgps_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .leg_stance_o     (leg_stance_o),
  .phase_index_o    (phase_index_o),
  .active_gait_o    (active_gait_o),
  .phase_advanced_o (phase_advanced_o)
);

`default_nettype wire

// ===== tb/legged_gait_phase_scheduler_top_tb.sv =====
`timescale 1ns / 100ps

module legged_gait_phase_scheduler_top_tb;

  localparam int unsigned TIME_BITS = lgps_pkg::TIME_BITS_DEF;
  localparam longint unsigned TIME_MAX = (64'd1 << TIME_BITS) - 1;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned TICKS_PER_PHASE = 76;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam logic [2:0] REG_SPARE = 3'd5;

  // rows per gait and stance pattern per row, bit i = leg i
  localparam int ROW_COUNT [4] = '{1, 2, 2, 4};
  localparam logic [3:0] STANCE_TABLE [4][4] = '{
    '{4'hF, 4'hF, 4'hF, 4'hF},
    '{4'h9, 4'h6, 4'h9, 4'h6},
    '{4'h3, 4'hC, 4'h3, 4'hC},
    '{4'hE, 4'h7, 4'hB, 4'hD}
  };

  // walks through switches, rejected switches, unused codes and both advance kinds
  localparam lgps_pkg::item_t DIRECTED_TICKS [25] = '{
    '{3'd0, 3'd0, 4'h0}, '{3'd1, 3'd3, 4'hF}, '{3'd1, 3'd3, 4'h0}, '{3'd1, 3'd3, 4'hF},
    '{3'd2, 3'd7, 4'hF}, '{3'd2, 3'd3, 4'hF}, '{3'd2, 3'd3, 4'hF}, '{3'd2, 3'd3, 4'hF},
    '{3'd2, 3'd3, 4'hF}, '{3'd3, 3'd1, 4'h8}, '{3'd3, 3'd1, 4'h5}, '{3'd3, 3'd1, 4'hA},
    '{3'd4, 3'd2, 4'hF}, '{3'd5, 3'd0, 4'h0}, '{3'd5, 3'd0, 4'hF}, '{3'd5, 3'd0, 4'hF},
    '{3'd5, 3'd0, 4'hF}, '{3'd6, 3'd4, 4'h3}, '{3'd7, 3'd3, 4'h0}, '{3'd7, 3'd3, 4'h0},
    '{3'd7, 3'd3, 4'h0}, '{3'd0, 3'd2, 4'h0}, '{3'd0, 3'd2, 4'h0}, '{3'd0, 3'd2, 4'h0},
    '{3'd0, 3'd2, 4'h1}
  };

  class gait_schedule_scoreboard;
    logic [lgps_pkg::TICK_W-1:0]   tick_us;
    logic [lgps_pkg::STANCE_W-1:0] stand_us;
    logic [lgps_pkg::STANCE_W-1:0] trot_us;
    logic [lgps_pkg::STANCE_W-1:0] pace_us;
    logic [lgps_pkg::STANCE_W-1:0] walk_us;
    logic [1:0]                    row;
    logic [TIME_BITS-1:0]          elapsed_us;
    lgps_pkg::gait_e               gait;
    logic [lgps_pkg::TAG_W-1:0]    tag;
    logic [3:0]                    prev_contact;
    lgps_pkg::res_t                expected_phases [$];
    int                            failures;

    function new();
      tick_us = lgps_pkg::TICK_RST;
      stand_us = lgps_pkg::STAND_RST;
      trot_us = lgps_pkg::TROT_RST;
      pace_us = lgps_pkg::PACE_RST;
      walk_us = lgps_pkg::WALK_RST;
      row = '0;
      elapsed_us = '0;
      gait = lgps_pkg::GAIT_STAND;
      tag = '0;
      prev_contact = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      unique case (idx)
        lgps_pkg::REG_TICK:  tick_us = value[lgps_pkg::TICK_W-1:0];
        lgps_pkg::REG_STAND: stand_us = value[lgps_pkg::STANCE_W-1:0];
        lgps_pkg::REG_TROT:  trot_us = value[lgps_pkg::STANCE_W-1:0];
        lgps_pkg::REG_PACE:  pace_us = value[lgps_pkg::STANCE_W-1:0];
        lgps_pkg::REG_WALK:  walk_us = value[lgps_pkg::STANCE_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_phases.size();
    endfunction

    function void note_tick(logic [2:0] req_tag, logic [2:0] sel, logic [3:0] contact);
      longint unsigned t_now;
      longint unsigned span;
      logic changed;
      logic advanced;
      lgps_pkg::res_t r;
      changed = 1'b0;
      advanced = 1'b0;
      if (req_tag != tag && elapsed_us <= lgps_pkg::SWITCH_WINDOW_US) begin
        tag = req_tag;
        if (sel <= 3) begin
          gait = lgps_pkg::gait_e'(sel[1:0]);
          changed = 1'b1;
          if (row >= ROW_COUNT[gait]) row = 2'd0;
        end
      end
      t_now = longint'(elapsed_us) + tick_us;
      if (t_now > TIME_MAX) t_now = TIME_MAX;
      unique case (gait)
        lgps_pkg::GAIT_STAND: begin
          if (t_now >= stand_us) t_now = 0;
        end
        lgps_pkg::GAIT_TROT: begin
          if (t_now > trot_us) advanced = 1'b1;
        end
        default: begin
          span = (gait == lgps_pkg::GAIT_PACE) ? pace_us : walk_us;
          // early advance only inside the window and on a rising contact count
          if (5 * t_now > 6 * span) advanced = 1'b1;
          else if (5 * t_now > 4 * span && $countones(contact) > $countones(prev_contact))
            advanced = 1'b1;
        end
      endcase
      if (advanced) begin
        t_now = 0;
        row = (row + 3'd1 >= ROW_COUNT[gait]) ? 2'd0 : row + 2'd1;
      end
      elapsed_us = t_now[TIME_BITS-1:0];
      prev_contact = contact;
      r.leg_stance = STANCE_TABLE[gait][row];
      r.phase_index = row;
      r.active_gait = gait;
      r.gait_changed = changed;
      r.phase_advanced = advanced;
      expected_phases.push_back(r);
    endfunction

    function void check_tick_result(logic [3:0] stance, logic [1:0] idx, logic [1:0] g,
                                    logic changed, logic advanced);
      lgps_pkg::res_t want;
      if (expected_phases.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result stance %h row %0d gait %0d chg %b adv %b",
                   $time, stance, idx, g, changed, advanced);
        return;
      end
      want = expected_phases.pop_front();
      if (stance !== want.leg_stance || idx !== want.phase_index ||
          g !== want.active_gait || changed !== want.gait_changed ||
          advanced !== want.phase_advanced) begin
        failures++;
        if (failures <= 10)
          $display("%0t: expected stance %h row %0d gait %0d chg %b adv %b, %s %h %0d %0d %b %b",
                   $time, want.leg_stance, want.phase_index, want.active_gait,
                   want.gait_changed, want.phase_advanced, "got",
                   stance, idx, g, changed, advanced);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lgps_pkg::ADDR_W-1:0] paddr = '0;
  logic [lgps_pkg::DATA_W-1:0] pwdata = '0;
  logic [lgps_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [lgps_pkg::TAG_W-1:0] request_tag_i = '0;
  logic [lgps_pkg::SEL_W-1:0] gait_select_i = '0;
  logic [lgps_pkg::LEG_COUNT-1:0] foot_contact_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [lgps_pkg::LEG_COUNT-1:0] leg_stance_o;
  logic [1:0] phase_index_o;
  logic [1:0] active_gait_o;
  logic gait_changed_o;
  logic phase_advanced_o;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned pressure_req = 0;
  int unsigned pressure_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  gait_schedule_scoreboard sb;

  legged_gait_phase_scheduler_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .request_tag_i    (request_tag_i),
    .gait_select_i    (gait_select_i),
    .foot_contact_i   (foot_contact_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .leg_stance_o     (leg_stance_o),
    .phase_index_o    (phase_index_o),
    .active_gait_o    (active_gait_o),
    .gait_changed_o   (gait_changed_o),
    .phase_advanced_o (phase_advanced_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (pressure_req != pressure_served) begin
      pressure_served <= pressure_req;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_tick_result(leg_stance_o, phase_index_o, active_gait_o,
                           gait_changed_o, phase_advanced_o);
  end

  task automatic write_reg_apb(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_setting(input logic [31:0] tick, input logic [31:0] stand,
                              input logic [31:0] trot, input logic [31:0] pace,
                              input logic [31:0] walk);
    write_reg_apb(lgps_pkg::REG_TICK, tick);
    write_reg_apb(lgps_pkg::REG_STAND, stand);
    write_reg_apb(lgps_pkg::REG_TROT, trot);
    write_reg_apb(lgps_pkg::REG_PACE, pace);
    write_reg_apb(lgps_pkg::REG_WALK, walk);
  endtask

  task automatic send_tick(input logic [2:0] req_tag, input logic [2:0] sel,
                           input logic [3:0] contact);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    request_tag_i <= req_tag;
    gait_select_i <= sel;
    foot_contact_i <= contact;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(req_tag, sel, contact);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [2:0] cur_tag;
    logic [2:0] sel;
    int unsigned switch_pct;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_setting(1000, 3000, 2500, 3000, 4000);
    foreach (DIRECTED_TICKS[i])
      send_tick(DIRECTED_TICKS[i].request_tag, DIRECTED_TICKS[i].gait_select,
                DIRECTED_TICKS[i].foot_contact);
    in_valid_i <= 1'b0;
    cur_tag = DIRECTED_TICKS[24].request_tag;

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      case (p)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
          load_setting(1000, 4000, 3000, 5000, 6000);
        end
        1: begin
          tx_idle_pct = 46;
          rx_stall_pct <= 0;
          load_setting(1, 1, 1, 1, 1);
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 46;
          load_setting(65535, 800000, 800000, 800000, 800000);
        end
        3: begin
          // zero stance times; the spare address must not disturb anything
          tx_idle_pct = 37;
          rx_stall_pct <= 37;
          load_setting(700, 0, 0, 0, 0);
          write_reg_apb(REG_SPARE, 32'h0000_1234);
        end
        default: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
          load_setting($urandom_range(1500, 200), $urandom_range(9000, 1000),
                       $urandom_range(9000, 1000), $urandom_range(9000, 1000),
                       $urandom_range(9000, 1000));
        end
      endcase
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if (p == 4 && n == 20) pressure_req <= pressure_req + 1;
        // request switches mostly while the switch window is still open
        switch_pct = (sb.elapsed_us <= lgps_pkg::SWITCH_WINDOW_US) ? 35 : 8;
        if ($urandom_range(99) < switch_pct) begin
          cur_tag = cur_tag + 3'($urandom_range(7, 1));
          sel = ($urandom_range(99) < 85) ? 3'($urandom_range(3)) : 3'($urandom_range(7, 4));
        end else begin
          sel = 3'($urandom_range(7));
        end
        send_tick(cur_tag, sel, 4'($urandom_range(15)));
      end
      in_valid_i <= 1'b0;
    end

    wait_drained();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
